/* rtl/core/ehe_pkg.sv */
// Shared types, codes and helpers for the escape Huffman encoder.
package ehe_pkg;

  // Fixed field widths
  localparam int SYM_W        = 8;
  localparam int CODE_FIELD_W = 16;
  localparam int LEN_W        = 5;
  localparam int IDX_W        = 5;
  localparam int COUNT_W      = 6;
  localparam int MODE_W       = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;
  localparam int RAW_BITS     = 8;
  localparam int BITS_W       = CODE_FIELD_W + RAW_BITS;
  localparam int WORD_W       = 32;
  localparam int TOTAL_W      = 5;
  localparam int PEND_W       = 3;

  // Parameter defaults
  localparam int TABLE_DEPTH_DEF  = 32;
  localparam int MAX_CODE_LEN_DEF = 16;

  // Input tdata layout, lowest bit first
  localparam int IN_INDEX_LSB  = 0;
  localparam int IN_SYMBOL_LSB = IN_INDEX_LSB + IDX_W;
  localparam int IN_CODE_LSB   = IN_SYMBOL_LSB + SYM_W;
  localparam int IN_LEN_LSB    = IN_CODE_LSB + CODE_FIELD_W;
  localparam int IN_BYTE_LSB   = IN_LEN_LSB + LEN_W;
  localparam int IN_USED_W     = IN_BYTE_LSB + SYM_W;
  localparam int IN_DATA_W     = ((IN_USED_W + 7) / 8) * 8;

  // Item kinds
  localparam logic [MODE_W-1:0] MODE_LOAD   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ENCODE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FLUSH  = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_LENGTH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_PACK
  } state_t;

  // Table write broadcast to every cell
  typedef struct packed {
    logic                    wr;
    logic [IDX_W-1:0]        index;
    logic [SYM_W-1:0]        symbol;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_W-1:0]        len;
  } load_t;

  // Query token walking down the cell chain
  typedef struct packed {
    logic                    valid;
    logic                    found;
    logic [SYM_W-1:0]        symbol;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_W-1:0]        len;
  } search_t;

  // Bits handed to the packer, right aligned
  typedef struct packed {
    logic              valid;
    logic [BITS_W-1:0] bits;
    logic [LEN_W-1:0]  nbits;
  } pack_req_t;

  // Packer status seen by the controller
  typedef struct packed {
    logic              busy;
    logic [PEND_W-1:0] pend_cnt;
  } pack_stat_t;

  // Ones in the low n bits of a code field
  function automatic logic [CODE_FIELD_W-1:0] low_mask(input logic [LEN_W-1:0] n);
    logic [CODE_FIELD_W-1:0] m;
    if (n >= LEN_W'(CODE_FIELD_W)) begin
      m = '1;
    end else begin
      m = (CODE_FIELD_W'(1) << n) - CODE_FIELD_W'(1);
    end
    return m;
  endfunction

endpackage

/* rtl/core/ehe_cell.sv */
// One table cell: holds one code entry and passes the query token on.
module ehe_cell #(
  parameter int IDX          = 0,
  parameter int MAX_CODE_LEN = ehe_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ehe_pkg::load_t               load_i,
  input  logic [ehe_pkg::COUNT_W-1:0]  entry_count_i,
  input  ehe_pkg::search_t             search_i,
  output ehe_pkg::search_t             search_o
);
  import ehe_pkg::*;

  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;
  localparam int CODE_W  = LEN_LIM;

  logic [SYM_W-1:0]        sym_r;
  logic [CODE_W-1:0]       code_r;
  logic [LEN_W-1:0]        len_r;
  logic [LEN_W-1:0]        len_clamp;
  logic [CODE_FIELD_W-1:0] code_clean;
  logic                    sel;
  logic                    hit;
  search_t                 search_r;
  search_t                 search_nxt;

  // Entry write: clamp length, drop code bits above it
  assign sel        = load_i.wr && (32'(load_i.index) == IDX);
  assign len_clamp  = (load_i.len > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : load_i.len;
  assign code_clean = load_i.code & low_mask(len_clamp);

  always_ff @(posedge clk) begin
    if (sel) begin
      sym_r  <= load_i.symbol;
      code_r <= code_clean[CODE_W-1:0];
      len_r  <= len_clamp;
    end
  end

  // First matching live entry claims the token
  assign hit = search_i.valid && !search_i.found && (32'(entry_count_i) > IDX) &&
               (sym_r == search_i.symbol);

  always_comb begin
    search_nxt = search_i;
    if (hit) begin
      search_nxt.found = 1'b1;
      search_nxt.code  = CODE_FIELD_W'(code_r);
      search_nxt.len   = len_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      search_r.valid <= 1'b0;
    end else begin
      search_r <= search_nxt;
    end
  end

  assign search_o = search_r;

endmodule

/* rtl/core/ehe_packer.sv */
// Bit packer: appends code bits MSB first and sends each full byte.
module ehe_packer (
  input  logic                clk,
  input  logic                rst_n,
  input  ehe_pkg::pack_req_t  req_i,
  output ehe_pkg::pack_stat_t stat_o,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,   // packed_byte[7:0]
  output logic                out_tlast    // last_of_run
);
  import ehe_pkg::*;

  logic [WORD_W-1:0]  word_r, word_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [7:0]         odata_r, odata_nxt;
  logic               olast_r, olast_nxt;
  logic [5:0]         shamt;
  logic               emit;

  // Left-aligned bit buffer; top byte goes out once eight bits are there and the output register is free
  assign emit  = (total_r >= TOTAL_W'(8)) && (!ovalid_r || out_tready);
  assign shamt = 6'd32 - 6'(total_r) - 6'(req_i.nbits);

  always_comb begin
    word_nxt   = word_r;
    total_nxt  = total_r;
    ovalid_nxt = ovalid_r && !out_tready;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (emit) begin
      odata_nxt  = word_r[WORD_W-1 -: 8];
      olast_nxt  = (total_r < TOTAL_W'(16));
      ovalid_nxt = 1'b1;
      word_nxt   = word_r << 8;
      total_nxt  = total_r - TOTAL_W'(8);
    end else if (req_i.valid) begin
      word_nxt  = {word_r[WORD_W-1 -: 8], 24'b0} | (WORD_W'(req_i.bits) << shamt);
      total_nxt = total_r + req_i.nbits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      word_r   <= '0;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      word_r   <= word_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  assign stat_o.busy     = (total_r >= TOTAL_W'(8));
  assign stat_o.pend_cnt = total_r[PEND_W-1:0];
  assign out_tvalid      = ovalid_r;
  assign out_tdata       = odata_r;
  assign out_tlast       = olast_r;

endmodule

/* rtl/core/escape_huffman_encoder_unit.sv */
// Top level of the escape Huffman encoder: control, config registers and cell chain.
//
// Byte stream encoder with a truncated Huffman table and an escape for unlisted
// bytes. Load items (tuser mode 0) write one table entry. Encode items (mode 1)
// send the byte as a query token down a chain of TABLE_DEPTH cells, one cell per
// cycle; the next item is taken only once the search is done and the packer has
// handed on all full output bytes (up to three) of the item. Flush items (mode 2)
// send the partial byte, zero padded. Code bits go out MSB first; tlast marks the
// final byte an item produces. The output byte sits in a register, so a new item
// can be taken while it waits. Configuration must only be written while no item
// is in flight. Table entries never loaded read as unknown.
module escape_huffman_encoder_unit #(
  parameter int TABLE_DEPTH  = ehe_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_CODE_LEN = ehe_pkg::MAX_CODE_LEN_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // entry_index[4:0], entry_symbol[12:5], entry_code[28:13], entry_length[33:29],
  // data_byte[41:34], zero fill above
  input  logic [ehe_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [ehe_pkg::MODE_W-1:0]       in_tuser,   // mode[1:0]
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata,  // packed_byte[7:0]
  output logic                             out_tlast,  // last_of_run
  // configuration
  input  logic                             cfg_we,
  input  logic [ehe_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ehe_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import ehe_pkg::*;

  localparam int LEN_LIM = (MAX_CODE_LEN < CODE_FIELD_W) ? MAX_CODE_LEN : CODE_FIELD_W;

  state_t                  state_r, state_nxt;
  logic [COUNT_W-1:0]      entry_count_r;
  logic [CODE_FIELD_W-1:0] escape_code_r;
  logic [LEN_W-1:0]        escape_length_r;
  logic                    in_acc;
  logic [MODE_W-1:0]       mode;
  load_t                   load;
  search_t                 link [TABLE_DEPTH+1];
  search_t                 tail;
  pack_req_t               req;
  pack_stat_t              pstat;
  logic [LEN_W-1:0]        esc_len;
  logic [CODE_FIELD_W-1:0] esc_code;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      escape_code_r   <= '0;
      escape_length_r <= LEN_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_COUNT:   entry_count_r   <= cfg_wdata[COUNT_W-1:0];
        CFG_ESCAPE_CODE:   escape_code_r   <= cfg_wdata;
        CFG_ESCAPE_LENGTH: escape_length_r <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc = in_tvalid && in_tready;
  assign mode   = in_tuser;

  // Table write broadcast
  assign load.wr     = in_acc && (mode == MODE_LOAD);
  assign load.index  = in_tdata[IN_INDEX_LSB +: IDX_W];
  assign load.symbol = in_tdata[IN_SYMBOL_LSB +: SYM_W];
  assign load.code   = in_tdata[IN_CODE_LSB +: CODE_FIELD_W];
  assign load.len    = in_tdata[IN_LEN_LSB +: LEN_W];

  // Query token enters the head of the chain
  assign link[0].valid  = in_acc && (mode == MODE_ENCODE);
  assign link[0].found  = 1'b0;
  assign link[0].symbol = in_tdata[IN_BYTE_LSB +: SYM_W];
  assign link[0].code   = '0;
  assign link[0].len    = '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ehe_cell #(
      .IDX          (i),
      .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .load_i        (load),
      .entry_count_i (entry_count_r),
      .search_i      (link[i]),
      .search_o      (link[i+1])
    );
  end

  assign tail = link[TABLE_DEPTH];

  // Escape code clamped and trimmed to its length
  assign esc_len  = (escape_length_r > LEN_W'(LEN_LIM)) ? LEN_W'(LEN_LIM) : escape_length_r;
  assign esc_code = escape_code_r & low_mask(esc_len);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && (mode == MODE_ENCODE)) begin
          state_nxt = ST_SEARCH;
        end else if (in_acc && (mode == MODE_FLUSH)) begin
          state_nxt = ST_PACK;
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          state_nxt = ST_PACK;
        end
      end
      ST_PACK: begin
        if (!pstat.busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs: ready and packer requests
  always_comb begin
    in_tready = 1'b0;
    req       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_acc && (mode == MODE_FLUSH) && (pstat.pend_cnt != '0)) begin
          req.valid = 1'b1;
          req.bits  = '0;
          req.nbits = LEN_W'(8) - LEN_W'(pstat.pend_cnt);
        end
      end
      ST_SEARCH: begin
        if (tail.valid) begin
          req.valid = 1'b1;
          if (tail.found) begin
            req.bits  = BITS_W'(tail.code);
            req.nbits = tail.len;
          end else begin
            req.bits  = {esc_code, tail.symbol};
            req.nbits = esc_len + LEN_W'(RAW_BITS);
          end
        end
      end
      ST_PACK: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  ehe_packer u_packer (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_i      (req),
    .stat_o     (pstat),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* tb/tb_escape_huffman_encoder_unit.sv */
// Self-checking testbench for the escape Huffman encoder unit.
`timescale 1ns / 100ps

module tb_escape_huffman_encoder_unit;
  import ehe_pkg::*;

  localparam logic [MODE_W-1:0] MODE_UNKNOWN = 2'd3;
  localparam int NUM_SLOTS      = TABLE_DEPTH_DEF;
  localparam int CODE_LEN_LIMIT = MAX_CODE_LEN_DEF;
  localparam int SETTLE_CYCLES  = 2 * (TABLE_DEPTH_DEF + 8);
  localparam int RX_HOLD_CYCLES = 400;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int IDLE_PCT       = 21;

  // One input transaction, unpacked
  typedef struct {
    logic [MODE_W-1:0]       mode;
    logic [IDX_W-1:0]        idx;
    logic [SYM_W-1:0]        sym;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_W-1:0]        len;
    logic [SYM_W-1:0]        data;
  } enc_item_t;

  // One expected output byte
  typedef struct {
    logic [7:0] data_val;
    logic       is_last;
  } out_byte_t;

  typedef struct {
    logic [SYM_W-1:0]        sym;
    logic [CODE_FIELD_W-1:0] code;
    logic [LEN_W-1:0]        len;
  } slot_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata  = '0;
  logic [MODE_W-1:0]     in_tuser  = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [7:0]            out_tdata;
  logic                  out_tlast;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state, mirrors the block after reset
  slot_t            code_table [NUM_SLOTS];
  logic [COUNT_W-1:0] entry_count_reg = '0;
  logic [CODE_FIELD_W-1:0] esc_code_reg = '0;
  logic [LEN_W-1:0] esc_len_reg = 5'd1;
  logic [7:0]       pend_bits = '0;
  int               pend_cnt = 0;
  out_byte_t        expected_bytes [$];
  out_byte_t        want_byte;

  // Run control
  int   mismatches = 0;
  int   cycle_count = 0;
  logic no_idle = 1'b0;
  logic hold_request = 1'b0;
  logic rx_hold = 1'b0;

  escape_huffman_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TIMEOUT after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] ERROR: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic int clamp_len(input logic [LEN_W-1:0] l);
    return (int'(l) > CODE_LEN_LIMIT) ? CODE_LEN_LIMIT : int'(l);
  endfunction

  // Append nbits right-aligned bits MSB first; queue every completed byte
  function automatic void pack_code_bits(input logic [BITS_W-1:0] bits, input int nbits);
    logic [63:0] acc;
    int total;
    int n_out;
    out_byte_t ob;
    acc = 64'(pend_bits) >> (8 - pend_cnt);
    acc = (acc << nbits) | (64'(bits) & ((64'd1 << nbits) - 64'd1));
    total = pend_cnt + nbits;
    n_out = total / 8;
    for (int k = 0; k < n_out; k++) begin
      total -= 8;
      ob.data_val = 8'(acc >> total);
      ob.is_last  = (k == n_out - 1);
      expected_bytes.push_back(ob);
    end
    pend_bits = 8'((acc & ((64'd1 << total) - 64'd1)) << (8 - total));
    pend_cnt  = total;
  endfunction

  function automatic void predict_packed_bytes(input enc_item_t it);
    int limit;
    int len;
    logic [BITS_W-1:0] bits;
    out_byte_t ob;
    case (it.mode)
      MODE_LOAD: begin
        code_table[it.idx] = '{sym: it.sym, code: it.code, len: it.len};
      end
      MODE_ENCODE: begin
        limit = (int'(entry_count_reg) > NUM_SLOTS) ? NUM_SLOTS : int'(entry_count_reg);
        for (int i = 0; i < limit; i++) begin
          if (code_table[i].sym == it.data) begin
            len = clamp_len(code_table[i].len);
            pack_code_bits(BITS_W'(code_table[i].code), len);
            return;
          end
        end
        // no entry: escape code, then the raw byte
        len  = clamp_len(esc_len_reg);
        bits = (BITS_W'(esc_code_reg) & ((BITS_W'(1) << len) - BITS_W'(1))) << RAW_BITS;
        bits = bits | BITS_W'(it.data);
        pack_code_bits(bits, len + RAW_BITS);
      end
      MODE_FLUSH: begin
        if (pend_cnt != 0) begin
          ob.data_val = pend_bits;
          ob.is_last  = 1'b1;
          expected_bytes.push_back(ob);
          pend_bits = '0;
          pend_cnt  = 0;
        end
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random ready, long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Hold-off counter
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
        hold_request <= 1'b0;
      end
    end
  end

  // Compare each output transaction with the oldest expected byte
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want_byte = expected_bytes.pop_front();
        if (out_tdata !== want_byte.data_val)
          report_mismatch($sformatf("packed_byte %02h, expected %02h",
                                    out_tdata, want_byte.data_val));
        if (out_tlast !== want_byte.is_last)
          report_mismatch($sformatf("last_of_run %0b, expected %0b (byte %02h)",
                                    out_tlast, want_byte.is_last, want_byte.data_val));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Offer one transaction, random gaps first; valid stays high afterwards
  task automatic send_item(input enc_item_t it);
    logic [IN_DATA_W-1:0] d;
    if (!no_idle) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    d = '0;
    d[IN_INDEX_LSB  +: IDX_W]        = it.idx;
    d[IN_SYMBOL_LSB +: SYM_W]        = it.sym;
    d[IN_CODE_LSB   +: CODE_FIELD_W] = it.code;
    d[IN_LEN_LSB    +: LEN_W]        = it.len;
    d[IN_BYTE_LSB   +: SYM_W]        = it.data;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= it.mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_packed_bytes(it);
  endtask

  // Stop offering, wait for every expected byte, then let the block settle
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_ENTRY_COUNT:   entry_count_reg = val[COUNT_W-1:0];
      CFG_ESCAPE_CODE:   esc_code_reg    = val;
      CFG_ESCAPE_LENGTH: esc_len_reg     = val[LEN_W-1:0];
      default: ;
    endcase
  endtask

  function automatic enc_item_t make_item(input logic [MODE_W-1:0] mode,
                                          input logic [IDX_W-1:0] idx,
                                          input logic [SYM_W-1:0] sym,
                                          input logic [CODE_FIELD_W-1:0] code,
                                          input logic [LEN_W-1:0] len,
                                          input logic [SYM_W-1:0] data);
    enc_item_t it;
    it = '{mode: mode, idx: idx, sym: sym, code: code, len: len, data: data};
    return it;
  endfunction

  // Random fields; encoded bytes reuse a table symbol about half the time
  function automatic enc_item_t random_item(input logic [MODE_W-1:0] mode);
    enc_item_t it;
    logic [SYM_W-1:0] pick;
    it.mode = mode;
    it.idx  = IDX_W'($urandom_range(NUM_SLOTS - 1));
    it.sym  = SYM_W'($urandom_range(255));
    it.code = CODE_FIELD_W'($urandom_range(16'hFFFF));
    it.len  = ($urandom_range(99) < 80) ? LEN_W'($urandom_range(1, 16))
                                        : LEN_W'($urandom_range(31));
    // only symbols of loaded slots are reused
    pick    = code_table[$urandom_range(NUM_SLOTS - 1)].sym;
    it.data = ($urandom_range(1) && !$isunknown(pick)) ? pick
                                                        : SYM_W'($urandom_range(255));
    return it;
  endfunction

  function automatic logic [MODE_W-1:0] random_mode();
    int r;
    r = $urandom_range(99);
    if (r < 10) return MODE_LOAD;
    if (r < 82) return MODE_ENCODE;
    if (r < 96) return MODE_FLUSH;
    return MODE_UNKNOWN;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty table: every byte goes out escaped, at several escape settings
  task automatic test_escape_path();
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h00));
    send_item(make_item(MODE_ENCODE, '1, '1, '1, '1, 8'hFF));
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h5C));  // literal backslash
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'hA5));
    send_item(make_item(MODE_UNKNOWN, '1, '1, '1, '1, '1));
    send_item(make_item(MODE_FLUSH, '0, '0, '0, '0, '0));
    send_item(make_item(MODE_FLUSH, '0, '0, '0, '0, '0));     // nothing pending
    // zero-length escape: raw byte only
    write_reg(CFG_ESCAPE_LENGTH, 16'd0);
    write_reg(CFG_ESCAPE_CODE, 16'hFFFF);
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h3C));
    write_reg(CFG_ESCAPE_LENGTH, 16'd16);
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h5C));
    // oversized escape length saturates
    write_reg(CFG_ESCAPE_LENGTH, 16'd31);
    write_reg(CFG_ESCAPE_CODE, 16'hA5A5);
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h80));
  endtask

  // Table hits: duplicates, zero and oversized lengths, excess code bits
  task automatic test_table_lookup();
    send_item(make_item(MODE_LOAD, 5'd0, 8'h5C, 16'hFFFF, 5'd16, '0));
    send_item(make_item(MODE_LOAD, 5'd1, 8'hFF, 16'h0000, 5'd1, '1));
    send_item(make_item(MODE_LOAD, 5'd2, 8'h00, 16'h0003, 5'd31, '0));
    send_item(make_item(MODE_LOAD, 5'd3, 8'h41, 16'hFFFF, 5'd0, '0));
    send_item(make_item(MODE_LOAD, 5'd4, 8'h5C, 16'h0001, 5'd2, '0));  // shadowed
    send_item(make_item(MODE_LOAD, 5'd5, 8'h80, 16'hABCD, 5'd5, '0));
    send_item(make_item(MODE_LOAD, 5'd31, 8'h7E, 16'h0000, 5'd7, '0)); // beyond count
    write_reg(CFG_ENTRY_COUNT, 16'd6);
    write_reg(CFG_ESCAPE_LENGTH, 16'd3);
    write_reg(CFG_ESCAPE_CODE, 16'hFFFD);
    send_item(make_item(MODE_ENCODE, '1, '1, '1, '1, 8'h5C));
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'hFF));
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h00));
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h41));  // sends no bits
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h80));
    send_item(make_item(MODE_ENCODE, '0, '0, '0, '0, 8'h7E));  // escaped
    send_item(make_item(MODE_FLUSH, '0, '0, '0, '0, '0));
  endtask

  // Receiver holds off while three-byte escapes keep coming in
  task automatic test_backpressure();
    write_reg(CFG_ENTRY_COUNT, 16'd0);
    write_reg(CFG_ESCAPE_LENGTH, 16'd16);
    hold_request = 1'b1;
    for (int k = 0; k < 16; k++) send_item(random_item(MODE_ENCODE));
    // sender pause until every byte has come out
    wait_drained();
    send_item(make_item(MODE_FLUSH, '0, '0, '0, '0, '0));
  endtask

  // Full random table, then random traffic under several register settings
  task automatic test_random_stream();
    enc_item_t it;
    logic [CFG_DATA_W-1:0] count_val;
    logic [CFG_DATA_W-1:0] len_val;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      it = random_item(MODE_LOAD);
      it.idx = IDX_W'(k);
      send_item(it);
    end
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin count_val = 16'd63; len_val = 16'd31; end
        1: begin count_val = 16'd32; len_val = 16'd16; end
        2: begin count_val = 16'd0;  len_val = 16'd0;  end
        3: begin count_val = 16'd1;  len_val = 16'd1;  end
        default: begin
          count_val = CFG_DATA_W'($urandom_range(63));
          len_val   = CFG_DATA_W'($urandom_range(31));
        end
      endcase
      write_reg(CFG_ENTRY_COUNT, count_val);
      write_reg(CFG_ESCAPE_CODE, CFG_DATA_W'($urandom_range(16'hFFFF)));
      write_reg(CFG_ESCAPE_LENGTH, len_val);
      // one phase runs at full rate on both sides
      if (phase == 1) no_idle <= 1'b1;
      for (int k = 0; k < 22; k++) send_item(random_item(random_mode()));
      if (phase == 1) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
        no_idle <= 1'b0;
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_escape_path();
    test_table_lookup();
    test_backpressure();
    test_random_stream();
    wait_drained();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* escape_huffman_encoder_unit.f */
rtl/core/ehe_pkg.sv
rtl/core/ehe_cell.sv
rtl/core/ehe_packer.sv
rtl/core/escape_huffman_encoder_unit.sv
tb/tb_escape_huffman_encoder_unit.sv
